// ===== sv/ntc_pkg.sv =====
package ntc_pkg;

    localparam int WORD_W = 64;
    localparam int CODE_W = 4;
    localparam int EXP_W  = 14;
    localparam int LZ_W   = 7;

    localparam logic [CODE_W-1:0] T_U8  = 4'd0;
    localparam logic [CODE_W-1:0] T_S8  = 4'd1;
    localparam logic [CODE_W-1:0] T_U16 = 4'd2;
    localparam logic [CODE_W-1:0] T_S16 = 4'd3;
    localparam logic [CODE_W-1:0] T_U32 = 4'd4;
    localparam logic [CODE_W-1:0] T_S32 = 4'd5;
    localparam logic [CODE_W-1:0] T_U64 = 4'd6;
    localparam logic [CODE_W-1:0] T_S64 = 4'd7;
    localparam logic [CODE_W-1:0] T_F32 = 4'd8;
    localparam logic [CODE_W-1:0] T_F64 = 4'd9;

    // mask of the bits a type occupies, zero for unassigned codes
    function automatic logic [WORD_W-1:0] type_mask(input logic [CODE_W-1:0] code);
        logic [WORD_W-1:0] m;
        case (code)
            T_U8, T_S8:          m = 64'h0000_0000_0000_00FF;
            T_U16, T_S16:        m = 64'h0000_0000_0000_FFFF;
            T_U32, T_S32, T_F32: m = 64'h0000_0000_FFFF_FFFF;
            T_U64, T_S64, T_F64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:             m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/numeric_type_converter_unit.sv =====
// channel  | handshake           | fields
// ---------+---------------------+-----------------------------------
// input    | in_valid, in_stall  | from_type, to_type, source_bits
// output   | out_valid, out_stall| result_bits, out_of_range
//
// four register stages: decode, normalize, align, round and pack
// one request per cycle while in_stall is low; a request passes the a, b and c registers before out_valid rises
// every stage holds while out_valid is high and out_stall is high
// rst_n clears only the stage valid bits
module numeric_type_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  from_type,
    input  logic [3:0]  to_type,
    input  logic [63:0] source_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_bits,
    output logic        out_of_range
);
    import ntc_pkg::*;

    // decoded request: value = mag * 2^e, or a ready-made direct result
    typedef struct packed {
        logic                    direct;
        logic [WORD_W-1:0]       dres;
        logic                    dflag;
        logic                    neg;
        logic                    inf;
        logic [WORD_W-1:0]       mag;
        logic signed [EXP_W-1:0] e;
        logic [CODE_W-1:0]       to;
    } dec_t;

    // normalized: msb of mn at bit 63, msb exponent ex
    typedef struct packed {
        logic                    direct;
        logic [WORD_W-1:0]       dres;
        logic                    dflag;
        logic                    neg;
        logic                    inf;
        logic                    zero;
        logic [WORD_W-1:0]       mn;
        logic signed [EXP_W-1:0] ex;
        logic [CODE_W-1:0]       to;
    } nrm_t;

    // aligned: integer part q, guard and sticky bits
    typedef struct packed {
        logic                    direct;
        logic [WORD_W-1:0]       dres;
        logic                    dflag;
        logic                    neg;
        logic                    zero;
        logic                    big;
        logic [WORD_W-1:0]       q;
        logic                    g;
        logic                    s;
        logic signed [EXP_W-1:0] ec;
        logic [CODE_W-1:0]       to;
    } aln_t;

    logic advance;
    logic a_valid_reg, b_valid_reg, c_valid_reg, out_valid_reg;
    dec_t a_reg, a_next;
    nrm_t b_reg, b_next;
    aln_t c_reg, c_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              flag_reg, flag_next;

    // whole pipe moves together; it only holds when the output is stuck
    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign out_valid = out_valid_reg;
    assign result_bits  = res_reg;
    assign out_of_range = flag_reg;

    // ---------------- stage a: decode ----------------
    always_comb
    begin
        logic [WORD_W-1:0] src;
        logic [WORD_W-1:0] v;
        logic              sneg;
        logic [10:0]       ef;
        logic [51:0]       frac;
        logic              emax_hit;
        logic              ezero;

        src  = source_bits & type_mask(from_type);
        v    = src;
        sneg = 1'b0;
        ef   = '0;
        frac = '0;
        emax_hit = 1'b0;
        ezero    = 1'b0;

        a_next        = '0;
        a_next.to     = to_type;

        if (from_type > T_F64 || to_type > T_F64)
        begin
            a_next.direct = 1'b1;
        end
        else if (from_type == to_type)
        begin
            a_next.direct = 1'b1;
            a_next.dres   = src;
        end
        else if (from_type < T_F32)
        begin
            case (from_type)
                T_S8:    v = {{56{src[7]}}, src[7:0]};
                T_S16:   v = {{48{src[15]}}, src[15:0]};
                T_S32:   v = {{32{src[31]}}, src[31:0]};
                default: v = src;
            endcase
            sneg = from_type[0] && v[63];
            if (to_type < T_F32)
            begin
                a_next.direct = 1'b1;
                a_next.dres   = v & type_mask(to_type);
            end
            else
            begin
                a_next.neg = sneg;
                a_next.mag = sneg ? (64'd0 - v) : v;
                a_next.e   = '0;
            end
        end
        else
        begin
            if (from_type == T_F32)
            begin
                sneg     = src[31];
                ef       = {3'b000, src[30:23]};
                frac     = {29'd0, src[22:0]};
                emax_hit = (src[30:23] == 8'hFF);
                ezero    = (src[30:23] == 8'h00);
            end
            else
            begin
                sneg     = src[63];
                ef       = src[62:52];
                frac     = src[51:0];
                emax_hit = (src[62:52] == 11'h7FF);
                ezero    = (src[62:52] == 11'h000);
            end
            a_next.neg = sneg;
            a_next.inf = emax_hit && (frac == '0);
            a_next.mag = {12'd0, frac};
            if (from_type == T_F32)
            begin
                a_next.e = -EXP_W'(149);
                if (!ezero && !emax_hit)
                begin
                    a_next.mag = {40'd0, 1'b1, frac[22:0]};
                    a_next.e   = EXP_W'(signed'({1'b0, ef})) - EXP_W'(150);
                end
            end
            else
            begin
                a_next.e = -EXP_W'(1074);
                if (!ezero && !emax_hit)
                begin
                    a_next.mag = {11'd0, 1'b1, frac};
                    a_next.e   = EXP_W'(signed'({1'b0, ef})) - EXP_W'(1075);
                end
            end
            // nan, and infinity between float formats, bypass the datapath
            // nan fraction keeps its top bits, quiet bit forced on
            if (emax_hit && frac != '0)
            begin
                a_next.direct = 1'b1;
                if (to_type < T_F32)
                begin
                    a_next.dflag = 1'b1;
                end
                else if (to_type == T_F64)
                begin
                    a_next.dres = {sneg, 11'h7FF, 1'b1, frac[21:0], 29'd0};
                end
                else
                begin
                    a_next.dres = {32'd0, sneg, 8'hFF, 1'b1, frac[50:29]};
                end
            end
            else if (emax_hit && to_type >= T_F32)
            begin
                a_next.direct = 1'b1;
                a_next.dres   = (to_type == T_F64) ? {sneg, 11'h7FF, 52'd0}
                                                   : {32'd0, sneg, 8'hFF, 23'd0};
            end
        end
    end

    // ---------------- stage b: normalize ----------------
    logic [LZ_W-1:0] lz;

    ntc_lzc u_lzc (
        .value (a_reg.mag),
        .lz    (lz)
    );

    always_comb
    begin
        b_next.direct = a_reg.direct;
        b_next.dres   = a_reg.dres;
        b_next.dflag  = a_reg.dflag;
        b_next.neg    = a_reg.neg;
        b_next.inf    = a_reg.inf;
        b_next.zero   = lz[LZ_W-1];
        b_next.mn     = a_reg.mag << lz[LZ_W-2:0];
        b_next.ex     = EXP_W'(63) - EXP_W'(signed'({1'b0, lz})) + a_reg.e;
        b_next.to     = a_reg.to;
    end

    // ---------------- stage c: align ----------------
    always_comb
    begin
        logic signed [EXP_W:0] rr;
        logic signed [EXP_W:0] lsb;
        logic signed [EXP_W:0] minlsb;
        logic signed [EXP_W:0] mb;
        logic [6:0]            r;
        logic [127:0]          w;

        mb     = (b_reg.to == T_F32) ? (EXP_W+1)'(23) : (EXP_W+1)'(52);
        minlsb = (b_reg.to == T_F32) ? -(EXP_W+1)'(149) : -(EXP_W+1)'(1074);
        lsb    = (EXP_W+1)'(b_reg.ex) - mb;
        if (lsb < minlsb)
        begin
            lsb = minlsb;
        end
        if (b_reg.to < T_F32)
        begin
            rr = (EXP_W+1)'(63) - (EXP_W+1)'(b_reg.ex);
        end
        else
        begin
            rr = lsb - (EXP_W+1)'(b_reg.ex) + (EXP_W+1)'(63);
        end
        if (rr < 0)
        begin
            r = 7'd0;
        end
        else if (rr > (EXP_W+1)'(127))
        begin
            r = 7'd127;
        end
        else
        begin
            r = rr[6:0];
        end
        w = {b_reg.mn, 64'd0} >> r;

        c_next.direct = b_reg.direct;
        c_next.dres   = b_reg.dres;
        c_next.dflag  = b_reg.dflag;
        c_next.neg    = b_reg.neg;
        c_next.zero   = b_reg.zero;
        c_next.big    = b_reg.inf || (!b_reg.zero && b_reg.ex >= EXP_W'(64));
        c_next.q      = w[127:64];
        c_next.g      = w[63];
        c_next.s      = |w[62:0];
        c_next.ec     = EXP_W'(lsb + mb);
        c_next.to     = b_reg.to;
    end

    // ---------------- stage d: round, pack or saturate ----------------
    always_comb
    begin
        logic [WORD_W-1:0]       q;
        logic [WORD_W-1:0]       bits;
        logic [WORD_W-1:0]       mask;
        logic [WORD_W-1:0]       maxpos;
        logic [WORD_W-1:0]       maxneg;
        logic signed [EXP_W-1:0] biased;

        mask   = type_mask(c_reg.to);
        maxpos = c_reg.to[0] ? (mask >> 1) : mask;
        maxneg = c_reg.to[0] ? (maxpos + 64'd1) : 64'd0;
        q      = c_reg.q + {63'd0, c_reg.g && (c_reg.s || c_reg.q[0])};
        bits   = '0;
        biased = '0;
        flag_next = 1'b0;
        res_next  = '0;

        if (c_reg.direct)
        begin
            res_next  = c_reg.dres;
            flag_next = c_reg.dflag;
        end
        else if (c_reg.to < T_F32)
        begin
            if (c_reg.neg)
            begin
                if (c_reg.big || c_reg.q > maxneg)
                begin
                    flag_next = 1'b1;
                    res_next  = (64'd0 - maxneg) & mask;
                end
                else
                begin
                    res_next = (64'd0 - c_reg.q) & mask;
                end
            end
            else if (c_reg.big || c_reg.q > maxpos)
            begin
                flag_next = 1'b1;
                res_next  = maxpos;
            end
            else
            begin
                res_next = c_reg.q;
            end
        end
        else if (c_reg.to == T_F32)
        begin
            biased = c_reg.ec + EXP_W'(126);
            bits   = ({52'd0, biased[11:0]} << 23) + q;
            if (bits >= (64'd255 << 23))
            begin
                bits = 64'd255 << 23;
            end
            if (c_reg.zero)
            begin
                bits = '0;
            end
            res_next = {32'd0, c_reg.neg, bits[30:0]};
        end
        else
        begin
            biased = c_reg.ec + EXP_W'(1022);
            bits   = ({52'd0, biased[11:0]} << 52) + q;
            if (bits >= (64'd2047 << 52))
            begin
                bits = 64'd2047 << 52;
            end
            if (c_reg.zero)
            begin
                bits = '0;
            end
            res_next = {c_reg.neg, bits[62:0]};
        end
        res_next = res_next & mask;
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            res_reg  <= res_next;
            flag_reg <= flag_next;
        end
    end

endmodule

// ===== sv/ntc_lzc.sv =====
module ntc_lzc (
    input  logic [63:0] value,
    output logic [6:0]  lz
);
    import ntc_pkg::*;

    // highest set bit wins; all zero gives the full width
    always_comb
    begin
        lz = 7'd64;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (value[i])
            begin
                lz = 7'(WORD_W - 1 - i);
            end
        end
    end

endmodule

// ===== tb/numeric_type_converter_unit_tb.sv =====
module numeric_type_converter_unit_tb;
    import ntc_pkg::*;

    // conversion result carried through the scoreboard
    typedef struct packed {
        logic [63:0] bits;
        logic        flag;
    } conv_result_t;

    // integer field helpers
    function automatic int code_width(input logic [3:0] code);
        case (code)
            T_U8, T_S8:          return 8;
            T_U16, T_S16:        return 16;
            T_U32, T_S32, T_F32: return 32;
            default:             return 64;
        endcase
    endfunction

    function automatic logic [63:0] width_ones(input int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic int top_bit(input logic [63:0] m);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (m[i])
                p = i;
        return p;
    endfunction

    // round to nearest even and pack value m * 2^e into a float
    function automatic logic [63:0] encode_float(input logic neg, input logic [63:0] m,
                                                 input int e, input int mb, input int eb);
        int          bias;
        int          lsb;
        int          sh;
        logic [63:0] emax;
        logic [63:0] sgn;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        bias = (1 << (eb - 1)) - 1;
        emax = (64'd1 << eb) - 64'd1;
        sgn  = neg ? (64'd1 << (mb + eb)) : 64'd0;
        if (m == 0)
            return sgn;
        lsb = top_bit(m) + e - mb;
        if (lsb < 1 - bias - mb)
            lsb = 1 - bias - mb;
        sh = lsb - e;
        if (sh <= 0)
            q = m << (-sh);
        else if (sh > 64)
            q = '0;
        else if (sh == 64)
            q = (m > (64'd1 << 63)) ? 64'd1 : 64'd0;
        else
        begin
            rem  = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q    = m >> sh;
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
        end
        bits = (64'(lsb + mb + bias - 1) << mb) + q;
        if (bits >= (emax << mb))
            bits = emax << mb;
        return sgn | bits;
    endfunction

    function automatic conv_result_t convert(input logic [3:0] from, input logic [3:0] to,
                                             input logic [63:0] raw);
        conv_result_t r;
        logic [63:0]  src;
        logic [63:0]  v;
        logic [63:0]  mag;
        logic [63:0]  m;
        logic [63:0]  frac;
        logic [63:0]  ef;
        logic [63:0]  emax;
        logic [63:0]  maxpos;
        logic [63:0]  maxneg;
        logic         neg;
        logic         inf;
        logic         nan;
        logic         big;
        int           fw;
        int           mb;
        int           eb;
        int           bias;
        int           e;
        r = '0;
        if (from > T_F64 || to > T_F64)
            return r;
        fw  = code_width(from);
        src = raw & width_ones(fw);
        if (from == to)
            r.bits = src;
        else if (from < T_F32)
        begin
            v = src;
            if (from[0] && fw < 64 && src[fw-1])
                v = v | ~width_ones(fw);
            neg = from[0] && v[63];
            if (to < T_F32)
                r.bits = v;
            else
            begin
                mag = neg ? -v : v;
                r.bits = (to == T_F32) ? encode_float(neg, mag, 0, 23, 8)
                                       : encode_float(neg, mag, 0, 52, 11);
            end
        end
        else
        begin
            mb   = (from == T_F32) ? 23 : 52;
            eb   = (from == T_F32) ? 8 : 11;
            bias = (1 << (eb - 1)) - 1;
            emax = (64'd1 << eb) - 64'd1;
            neg  = src[mb + eb];
            ef   = (src >> mb) & emax;
            frac = src & width_ones(mb);
            inf  = (ef == emax) && frac == 0;
            nan  = (ef == emax) && frac != 0;
            m    = frac;
            e    = 1 - bias - mb;
            if (ef != 0 && ef != emax)
            begin
                m = frac | (64'd1 << mb);
                e = int'(ef) - bias - mb;
            end
            if (to < T_F32)
            begin
                // truncate toward zero, saturate with flag
                fw     = code_width(to);
                maxpos = to[0] ? (width_ones(fw) >> 1) : width_ones(fw);
                maxneg = to[0] ? maxpos + 64'd1 : 64'd0;
                mag    = '0;
                big    = inf;
                if (nan)
                    r.flag = 1'b1;
                else
                begin
                    if (!inf && m != 0)
                    begin
                        if (e >= 0)
                        begin
                            if (top_bit(m) + e >= 64)
                                big = 1'b1;
                            else
                                mag = m << e;
                        end
                        else if (-e < 64)
                            mag = m >> (-e);
                    end
                    if (neg)
                    begin
                        if (big || mag > maxneg)
                        begin
                            r.flag = 1'b1;
                            r.bits = -maxneg;
                        end
                        else
                            r.bits = -mag;
                    end
                    else if (big || mag > maxpos)
                    begin
                        r.flag = 1'b1;
                        r.bits = maxpos;
                    end
                    else
                        r.bits = mag;
                end
            end
            else if (to == T_F64)
            begin
                if (nan)
                    r.bits = {neg, 11'h7FF, 1'b1, 51'd0} | (frac << 29);
                else if (inf)
                    r.bits = {neg, 11'h7FF, 52'd0};
                else
                    r.bits = encode_float(neg, m, e, 52, 11);
            end
            else
            begin
                if (nan)
                    r.bits = {32'd0, neg, 8'hFF, 1'b1, 22'd0} | (frac >> 29);
                else if (inf)
                    r.bits = {32'd0, neg, 8'hFF, 23'd0};
                else
                    r.bits = encode_float(neg, m, e, 23, 8);
            end
        end
        r.bits = r.bits & width_ones(code_width(to));
        return r;
    endfunction

    // in-order store of predicted conversions
    class conversion_scoreboard;
        conv_result_t pending[$];
        int           errors;
        int           matched;

        function void note_request(input logic [3:0] from, input logic [3:0] to,
                                   input logic [63:0] raw);
            pending.push_back(convert(from, to, raw));
        endfunction

        function void check_result(input logic [63:0] bits, input logic flag);
            conv_result_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result bits=%h flag=%b", bits, flag);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (bits !== x.bits)
            begin
                $error("result_bits expected %h actual %h", x.bits, bits);
                errors++;
            end
            if (flag !== x.flag)
            begin
                $error("out_of_range expected %b actual %b", x.flag, flag);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  from_type;
    logic [3:0]  to_type;
    logic [63:0] source_bits;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_bits;
    logic        out_of_range;

    conversion_scoreboard board;
    longint               cycles = 0;
    int                   sent;
    int                   flagged;

    localparam longint CYCLE_LIMIT = 400000;

    numeric_type_converter_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .from_type    (from_type),
        .to_type      (to_type),
        .source_bits  (source_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_bits  (result_bits),
        .out_of_range (out_of_range)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // gap length: mostly zero or short, occasionally long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one request and hold it until accepted
    task automatic send_request(input logic [3:0] from, input logic [3:0] to,
                                input logic [63:0] raw);
        in_valid    <= 1'b1;
        from_type   <= from;
        to_type     <= to;
        source_bits <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(from, to, raw);
        sent++;
    endtask

    task automatic send_with_gap(input logic [3:0] from, input logic [3:0] to,
                                 input logic [63:0] raw, input bit calm);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        send_request(from, to, raw);
    endtask

    // random operand for the source type, with interesting exponents for float types
    function automatic logic [63:0] random_source(input logic [3:0] from);
        logic [63:0] r;
        int          k;
        r = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (from == T_F32)
        begin
            case (k)
                0: r[30:23] = 8'hFF;
                1: r[30:23] = 8'h00;
                2, 3, 4: r[30:23] = 8'(127 + $urandom_range(0, 66) - 2);
                default: ;
            endcase
        end
        else if (from == T_F64)
        begin
            case (k)
                0: r[62:52] = 11'h7FF;
                1: r[62:52] = 11'h000;
                2, 3, 4: r[62:52] = 11'(1023 + $urandom_range(0, 66) - 2);
                5: r[62:52] = 11'(896 + $urandom_range(0, 260) - 130);
                default: ;
            endcase
        end
        else if (k < 3)
            r = r >> $urandom_range(0, 63);
        else if (k == 3)
            r = ~(r >> $urandom_range(0, 63));
        return r;
    endfunction

    // receiver: random stalls, checks each accepted result
    initial
    begin
        int g;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                board.check_result(result_bits, out_of_range);
                if (out_of_range)
                    flagged++;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            out_stall <= (g > 0) && ($urandom_range(0, 1) == 0);
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        board        = new();
        sent         = 0;
        flagged      = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        from_type    = '0;
        to_type      = '0;
        source_bits  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, infinities, nans, saturation, rounding ties
        send_request(T_S8, T_S64, 64'h80);
        send_request(T_U64, T_U64, '1);
        send_request(T_S64, T_U8, 64'h8000_0000_0000_0000);
        send_request(T_U64, T_F32, '1);
        send_request(T_S64, T_F64, 64'h8000_0000_0000_0001);
        send_request(T_U32, T_F32, 64'h0100_0001);
        send_request(T_U32, T_F32, 64'h0100_0003);
        send_request(T_F32, T_S32, 64'h7F80_0000);
        send_request(T_F32, T_U16, 64'hFF80_0000);
        send_request(T_F64, T_S64, 64'hFFF8_0000_0000_0001);
        send_request(T_F32, T_F64, 64'hFFC0_1234);
        send_request(T_F64, T_F32, 64'h7FF0_0000_2000_0001);
        send_request(T_F64, T_F32, 64'h47F0_0000_0000_0000);
        send_request(T_F64, T_F32, 64'h3690_0000_0000_0000);
        send_request(T_F64, T_F32, 64'h8000_0000_0000_0001);
        send_request(T_F32, T_U8, 64'hBF7F_FFFF);
        send_request(T_F32, T_U8, 64'hBF80_0000);
        send_request(T_F64, T_S8, 64'hC060_0000_0000_0000);
        send_request(T_F64, T_S8, 64'hC060_2000_0000_0000);
        send_request(T_F32, T_F32, 64'hFFFF_FFFF_7FC0_0001);
        send_request(4'd10, T_U8, 64'h55);
        send_request(T_U8, 4'd15, 64'h55);
        send_request(T_F32, T_F64, 64'h0000_0001);
        send_request(T_F64, T_U64, 64'h43F0_0000_0000_0000);

        // random: mostly valid codes, a few unassigned
        for (int i = 0; i < 1600; i++)
        begin
            logic [3:0] f;
            logic [3:0] t;
            f = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            t = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            send_with_gap(f, t, random_source(f), (i / 200) % 2 == 1);
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d conversions across all type pairs, %0d results checked, %0d saturated",
                 sent, board.matched, flagged);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
